// ----- rtl/upq_pkg.sv -----
// ----------------------------------------------------------------------------
// upq_pkg
// Shared types, constants and helpers of the unsorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package upq_pkg;

  // Storage geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int REQ_W  = 2;
  localparam int PRIO_W = 16;
  localparam int PAY_W  = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;
  localparam int ENTRY_W = PRIO_W + PAY_W;

  // Common width for comparing a position against the fill count
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REPLACE = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [PRIO_W-1:0] item_priority;
    logic [PAY_W-1:0]  item_payload;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [PRIO_W-1:0] out_priority;
    logic [PAY_W-1:0]  out_payload;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } ram_cmd_t;

  // True when candidate c displaces current best b
  function automatic logic beats(input logic order, input logic [PRIO_W-1:0] c,
                                 input logic [PRIO_W-1:0] b);
    logic r;
    r = order ? (c < b) : (c > b);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/upq_req_if.sv -----
// ----------------------------------------------------------------------------
// upq_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface upq_req_if;
  import upq_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [PRIO_W-1:0] item_priority;
  logic [PAY_W-1:0]  item_payload;
  logic [POS_W-1:0]  position;

  modport source (
    output valid, req_type, item_priority, item_payload, position,
    input  ready
  );

  modport sink (
    input  valid, req_type, item_priority, item_payload, position,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/upq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// upq_rsp_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface upq_rsp_if;
  import upq_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PRIO_W-1:0] out_priority;
  logic [PAY_W-1:0]  out_payload;
  logic [OCC_W-1:0]  occupancy;

  modport source (
    output valid, status, out_priority, out_payload, occupancy,
    input  ready
  );

  modport sink (
    input  valid, status, out_priority, out_payload, occupancy,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/unsorted_priority_queue_core.sv -----
// Timing: enqueue, replace and rejected requests load the engine result register
//   on acceptance; a dequeue loads it once its scan and its shift are done.
// Throughput: one request at a time, the next taken in the cycle after the result
//   leaves the engine; a dequeue sweeps all entries, then the tail to shift.
// Reset: entry count and order_select clear; entry storage is left as is and
//   needs no clearing pass, since only words of written positions are used.
// ----------------------------------------------------------------------------
// unsorted_priority_queue_core
// Unsorted-array priority queue with enqueue, dequeue-best and replace.
// ----------------------------------------------------------------------------
`default_nettype none

module unsorted_priority_queue_core (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data,
  upq_req_if.sink    request,
  upq_rsp_if.source  result
);
  import upq_pkg::*;

  logic     order_select;
  req_t     req;
  logic     eng_rsp_valid;
  logic     eng_rsp_ready;
  rsp_t     eng_rsp;
  ram_cmd_t ram_cmd;
  logic [ENTRY_W-1:0] ram_rdata;
  logic     out_valid;
  rsp_t     out_word;

  // Order register
  always_ff @(posedge clk) begin
    if (rst) begin
      order_select <= 1'b0;
    end else if (cfg_wr_en) begin
      order_select <= cfg_wr_data;
    end
  end

  assign req.req_type      = request.req_type;
  assign req.item_priority = request.item_priority;
  assign req.item_payload  = request.item_payload;
  assign req.position      = request.position;

  upq_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .order_select (order_select),
    .req_valid    (request.valid),
    .req          (req),
    .req_ready    (request.ready),
    .rsp_valid    (eng_rsp_valid),
    .rsp          (eng_rsp),
    .rsp_ready    (eng_rsp_ready),
    .ram_cmd      (ram_cmd),
    .ram_rdata    (ram_rdata)
  );

  upq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_cmd.we),
    .waddr (ram_cmd.waddr),
    .wdata (ram_cmd.wdata),
    .raddr (ram_cmd.raddr),
    .rdata (ram_rdata)
  );

  // Output word register: hold until taken, load when free
  assign eng_rsp_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_rsp_valid && eng_rsp_ready) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_rsp_valid && eng_rsp_ready) begin
      out_word <= eng_rsp;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_word.status;
  assign result.out_priority = out_word.out_priority;
  assign result.out_payload  = out_word.out_payload;
  assign result.occupancy    = out_word.occupancy;

endmodule

`default_nettype wire

// ----- rtl/upq_ram.sv -----
// ----------------------------------------------------------------------------
// upq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module upq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/upq_engine.sv -----
// ----------------------------------------------------------------------------
// upq_engine
// Request sequencer: enqueue/replace done from the idle state, scan then shift for dequeue.
// ----------------------------------------------------------------------------
`default_nettype none

module upq_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              order_select,
  input  wire logic              req_valid,
  input  wire upq_pkg::req_t     req,
  output logic                   req_ready,
  output logic                   rsp_valid,
  output upq_pkg::rsp_t          rsp,
  input  wire logic              rsp_ready,
  output upq_pkg::ram_cmd_t      ram_cmd,
  input  wire logic [upq_pkg::ENTRY_W-1:0] ram_rdata
);
  import upq_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [ADDR_W-1:0] best_idx, best_idx_next;
  logic [PRIO_W-1:0] best_prio, best_prio_next;
  logic [PAY_W-1:0]  best_pay, best_pay_next;
  logic              pend, pend_next;
  logic [ADDR_W-1:0] pend_addr, pend_addr_next;
  rsp_t              rs, rs_next;

  logic [PRIO_W-1:0] rd_prio;
  logic [PAY_W-1:0]  rd_pay;
  logic              take;
  logic [ADDR_W-1:0] sel_idx;

  assign rd_prio = ram_rdata[ENTRY_W-1:PAY_W];
  assign rd_pay  = ram_rdata[PAY_W-1:0];
  assign rsp     = rs;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    best_idx  <= best_idx_next;
    best_prio <= best_prio_next;
    best_pay  <= best_pay_next;
    pend_addr <= pend_addr_next;
    rs        <= rs_next;
  end

  // Next state, memory commands and handshakes
  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    best_idx_next  = best_idx;
    best_prio_next = best_prio;
    best_pay_next  = best_pay;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    rs_next        = rs;
    ram_cmd        = '0;
    req_ready      = 1'b0;
    rsp_valid      = 1'b0;
    take           = (idx == CNT_W'(1)) || beats(order_select, rd_prio, best_prio);
    sel_idx        = take ? ADDR_W'(idx - CNT_W'(1)) : best_idx;

    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          rs_next.status       = STAT_OK;
          rs_next.out_priority = '0;
          rs_next.out_payload  = '0;
          rs_next.occupancy    = OCC_W'(count);
          state_next           = S_DONE;
          case (req.req_type)
            REQ_ENQUEUE: begin
              if (count >= CNT_W'(DEPTH)) begin
                rs_next.status = STAT_FULL;
              end else begin
                ram_cmd.we        = 1'b1;
                ram_cmd.waddr     = ADDR_W'(count);
                ram_cmd.wdata     = {req.item_priority, req.item_payload};
                count_next        = count + CNT_W'(1);
                rs_next.occupancy = OCC_W'(count + CNT_W'(1));
              end
            end
            REQ_DEQUEUE: begin
              if (count == '0) begin
                rs_next.status = STAT_EMPTY;
              end else begin
                idx_next   = '0;
                state_next = S_SCAN;
              end
            end
            REQ_REPLACE: begin
              if (CMP_W'(req.position) >= CMP_W'(count)) begin
                rs_next.status = STAT_RANGE;
              end else begin
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = ADDR_W'(req.position);
                ram_cmd.wdata = {req.item_priority, req.item_payload};
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // Read entry idx; the word of entry idx-1 is on the read port
        ram_cmd.raddr = ADDR_W'(idx);
        if (idx != '0 && take) begin
          best_idx_next  = ADDR_W'(idx - CNT_W'(1));
          best_prio_next = rd_prio;
          best_pay_next  = rd_pay;
        end
        if (idx == count) begin
          idx_next   = CNT_W'(sel_idx) + CNT_W'(1);
          state_next = S_SHIFT;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end

      S_SHIFT: begin
        // Drop the winner: move each later entry down one place
        if (pend) begin
          ram_cmd.we    = 1'b1;
          ram_cmd.waddr = pend_addr;
          ram_cmd.wdata = ram_rdata;
        end
        if (idx < count) begin
          ram_cmd.raddr  = ADDR_W'(idx);
          pend_next      = 1'b1;
          pend_addr_next = ADDR_W'(idx - CNT_W'(1));
          idx_next       = idx + CNT_W'(1);
        end else begin
          count_next           = count - CNT_W'(1);
          rs_next.status       = STAT_OK;
          rs_next.out_priority = best_prio;
          rs_next.out_payload  = best_pay;
          rs_next.occupancy    = OCC_W'(count - CNT_W'(1));
          state_next           = S_DONE;
        end
      end

      S_DONE: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // A successful enqueue grows the count by one
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.req_type == REQ_ENQUEUE && count < CNT_W'(DEPTH)
    |=> count == $past(count) + CNT_W'(1))
    else $error("enqueue did not advance count");

  // Shift writes stay inside the held entries
  assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT && ram_cmd.we |-> CNT_W'(ram_cmd.waddr) < count)
    else $error("shift write beyond held entries");

  // Finishing a shift removes exactly one entry and presents the result
  assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT && idx >= count
    |=> state == S_DONE && count == $past(count) - CNT_W'(1))
    else $error("dequeue finish did not drop one entry");

  // A scan never starts on an empty queue
  assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> count != '0)
    else $error("scan with no entries");

endmodule

`default_nettype wire
